// ===== rtl/huffman_total_code_cost_defines.svh =====
// Assertion macros shared by the huffman_total_code_cost RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef HUFFMAN_TOTAL_CODE_COST_DEFINES_SVH
`define HUFFMAN_TOTAL_CODE_COST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HFTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hftc_pkg.sv =====
// Package for the Huffman code cost block: fixed widths and sequencer states.
// No dependencies; used by hftc_ctrl and huffman_total_code_cost.
`default_nettype none

package hftc_pkg;

  localparam int WEIGHT_W = 16;
  localparam int COST_W   = 33;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_FIN,
    ST_M_CHECK,
    ST_M_TAIL,
    ST_M_HEAD,
    ST_SD_L,
    ST_SD_R,
    ST_SD_END,
    ST_M_B0,
    ST_M_B,
    ST_FINISH
  } hftc_state_t;

endpackage

`default_nettype wire

// ===== rtl/hftc_heap_ram.sv =====
// Heap storage: one write port and one registered read port.
// A read of the address written in the same cycle returns the new data.
`default_nettype none

module hftc_heap_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 24
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hftc_ctrl.sv =====
// Sequencer for the Huffman code cost block: heap insert, pop, replace-top
// and the cost total. Drives hftc_heap_ram; uses hftc_pkg.
`default_nettype none

module hftc_ctrl #(
  parameter int MAX_SYMBOLS = 256,
  parameter int IDX_W = $clog2(MAX_SYMBOLS),
  parameter int ENT_W = hftc_pkg::WEIGHT_W + IDX_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [hftc_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                        in_last,
  output logic                             res_valid,
  output logic      [hftc_pkg::COST_W-1:0] res_cost,
  input  wire logic                        res_take,
  output logic                             mem_we,
  output logic      [IDX_W-1:0]            mem_waddr,
  output logic      [ENT_W-1:0]            mem_wdata,
  output logic      [IDX_W-1:0]            mem_raddr,
  input  wire logic [ENT_W-1:0]            mem_rdata
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int KW    = IDX_W + 1;

  hftc_pkg::hftc_state_t state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [hftc_pkg::COST_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic [ENT_W-1:0]            val_r, val_nxt;
  logic [ENT_W-1:0]            a_r, a_nxt;
  logic [ENT_W-1:0]            l_r, l_nxt;
  logic                        last_r, last_nxt;
  logic                        phase_r, phase_nxt;

  logic [KW-1:0]    kid_k;
  logic [KW-1:0]    kid1_k;
  logic [KW-1:0]    cnt_k;
  logic [KW-1:0]    ins_parent_k;
  logic [IDX_W-1:0] up_idx;
  logic [IDX_W-1:0] up_parent;
  logic             right_sel;
  logic [ENT_W-1:0] child_val;
  logic [IDX_W-1:0] child_idx;
  logic [KW-1:0]    next_kid_k;
  logic [ENT_W-1:0] pair_sum;
  logic             accept;

  function automatic logic [hftc_pkg::COST_W-1:0] sat_add(
    input logic [hftc_pkg::COST_W-1:0] a,
    input logic [hftc_pkg::COST_W-1:0] b
  );
    logic [hftc_pkg::COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[hftc_pkg::COST_W]) begin
      return hftc_pkg::COST_MAX;
    end
    return s[hftc_pkg::COST_W-1:0];
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == hftc_pkg::ST_IDLE);
  assign res_valid = (state_r == hftc_pkg::ST_FINISH);
  assign res_cost  = acc_r;

  // Heap index arithmetic: children at 2p+1 and 2p+2, parent at (p-1)/2.
  assign cnt_k        = KW'(count_r);
  assign kid_k        = (KW'(pos_r) << 1) | KW'(1);
  assign kid1_k       = kid_k + KW'(1);
  assign ins_parent_k = (cnt_k - KW'(1)) >> 1;
  assign up_idx       = (pos_r - IDX_W'(1)) >> 1;
  assign up_parent    = (up_idx - IDX_W'(1)) >> 1;

  assign right_sel  = (kid1_k < cnt_k) && (mem_rdata < l_r);
  assign child_val  = right_sel ? mem_rdata : l_r;
  assign child_idx  = right_sel ? kid1_k[IDX_W-1:0] : kid_k[IDX_W-1:0];
  assign next_kid_k = (KW'(child_idx) << 1) | KW'(1);
  assign pair_sum   = a_r + mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hftc_pkg::ST_IDLE;
      count_r <= '0;
      acc_r   <= '0;
      last_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    a_r   <= a_nxt;
    l_r   <= l_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    a_nxt     = a_r;
    l_nxt     = l_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = val_r;
    mem_raddr = '0;

    unique case (state_r)
      hftc_pkg::ST_IDLE: begin
        // The parent of the next free slot is read ahead of every insert.
        mem_raddr = ins_parent_k[IDX_W-1:0];
        if (accept) begin
          if (count_r < CNT_W'(MAX_SYMBOLS)) begin
            acc_nxt   = sat_add(acc_r, hftc_pkg::COST_W'(in_weight));
            count_nxt = count_r + CNT_W'(1);
            if (count_r == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = ENT_W'(in_weight);
              state_nxt = in_last ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_IDLE;
            end else begin
              pos_nxt   = count_r[IDX_W-1:0];
              val_nxt   = ENT_W'(in_weight);
              last_nxt  = in_last;
              state_nxt = hftc_pkg::ST_PUSH;
            end
          end else begin
            state_nxt = in_last ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_IDLE;
          end
        end
      end

      hftc_pkg::ST_PUSH: begin
        mem_we = 1'b1;
        if (mem_rdata <= val_r) begin
          state_nxt = last_r ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          pos_nxt   = up_idx;
          if (up_idx == '0) begin
            state_nxt = hftc_pkg::ST_PUSH_FIN;
          end else begin
            mem_raddr = up_parent;
          end
        end
      end

      hftc_pkg::ST_PUSH_FIN: begin
        mem_we    = 1'b1;
        state_nxt = last_r ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_IDLE;
      end

      hftc_pkg::ST_M_CHECK: begin
        mem_raddr = IDX_W'(count_r - CNT_W'(1));
        if (count_r <= CNT_W'(1)) begin
          state_nxt = hftc_pkg::ST_FINISH;
        end else begin
          state_nxt = hftc_pkg::ST_M_TAIL;
        end
      end

      hftc_pkg::ST_M_TAIL: begin
        val_nxt   = mem_rdata;
        mem_raddr = '0;
        state_nxt = hftc_pkg::ST_M_HEAD;
      end

      hftc_pkg::ST_M_HEAD: begin
        a_nxt     = mem_rdata;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = '0;
        phase_nxt = 1'b0;
        mem_raddr = IDX_W'(1);
        if (count_r > CNT_W'(2)) begin
          state_nxt = hftc_pkg::ST_SD_L;
        end else begin
          state_nxt = hftc_pkg::ST_SD_END;
        end
      end

      hftc_pkg::ST_SD_L: begin
        l_nxt     = mem_rdata;
        mem_raddr = kid1_k[IDX_W-1:0];
        state_nxt = hftc_pkg::ST_SD_R;
      end

      hftc_pkg::ST_SD_R: begin
        mem_we = 1'b1;
        if (child_val < val_r) begin
          mem_wdata = child_val;
          pos_nxt   = child_idx;
          if (next_kid_k < cnt_k) begin
            mem_raddr = next_kid_k[IDX_W-1:0];
            state_nxt = hftc_pkg::ST_SD_L;
          end else begin
            state_nxt = hftc_pkg::ST_SD_END;
          end
        end else begin
          state_nxt = phase_r ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_M_B0;
        end
      end

      hftc_pkg::ST_SD_END: begin
        mem_we    = 1'b1;
        state_nxt = phase_r ? hftc_pkg::ST_M_CHECK : hftc_pkg::ST_M_B0;
      end

      hftc_pkg::ST_M_B0: begin
        mem_raddr = '0;
        state_nxt = hftc_pkg::ST_M_B;
      end

      hftc_pkg::ST_M_B: begin
        // The root now holds the second smallest entry; it is replaced by the sum.
        if (count_r == CNT_W'(1)) begin
          state_nxt = hftc_pkg::ST_FINISH;
        end else begin
          acc_nxt   = sat_add(acc_r, hftc_pkg::COST_W'(pair_sum));
          val_nxt   = pair_sum;
          pos_nxt   = '0;
          phase_nxt = 1'b1;
          mem_raddr = IDX_W'(1);
          state_nxt = hftc_pkg::ST_SD_L;
        end
      end

      hftc_pkg::ST_FINISH: begin
        if (res_take) begin
          count_nxt = '0;
          acc_nxt   = '0;
          state_nxt = hftc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hftc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/huffman_total_code_cost.sv =====
// Huffman total code cost. Weights stream in on the in_ channel, one transaction
// per symbol, with in_last marking the final symbol of a set. Each weight is
// added to a running total and inserted into a binary min-heap held in a
// simple dual-port synchronous RAM (one write and one registered read per cycle).
// After the marked weight the block merges the two smallest entries until one
// remains, adding every merged sum except the root, and returns the total code
// cost (the weighted path length) as one out_ transaction. A set with a single
// weight returns that weight. Weights beyond MAX_SYMBOLS in one set are dropped,
// and the total saturates at all ones. An insert is accepted and then sifted up
// one heap level at a time through the RAM read port; no new weight is taken
// until it is done. Each merge reads the tail and the root, sifts down, rereads
// the root and sifts down again, one level at a time. The result sits in an
// output register, so the block takes the next weight while the result waits
// to be taken.
// Depends on hftc_pkg, hftc_ctrl, hftc_heap_ram and the assertion macro header.
`default_nettype none

`include "huffman_total_code_cost_defines.svh"

module huffman_total_code_cost #(
  parameter int MAX_SYMBOLS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hftc_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [hftc_pkg::COST_W-1:0]   out_total_cost
);

  // Heap entries must hold the sum of every weight in a full set.
  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int ENT_W = hftc_pkg::WEIGHT_W + IDX_W;

  logic                        res_valid;
  logic [hftc_pkg::COST_W-1:0] res_cost;
  logic                        res_take;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ENT_W-1:0]            mem_wdata;
  logic [IDX_W-1:0]            mem_raddr;
  logic [ENT_W-1:0]            mem_rdata;

  logic                        out_valid_r, out_valid_nxt;
  logic [hftc_pkg::COST_W-1:0] out_cost_r, out_cost_nxt;

  hftc_ctrl #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_weight (in_weight),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res_cost  (res_cost),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  hftc_heap_ram #(
    .DEPTH  (MAX_SYMBOLS),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The sequencer hands its total over whenever the output register is empty
  // or is being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cost_nxt  = out_cost_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_cost_nxt  = res_cost;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cost_r <= out_cost_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = out_cost_r;

  // A handed-over total must appear in the output register on the next cycle.
  `HFTC_ASSERT_NEXT(a_result_lands, res_take, out_valid_r && (out_cost_r == $past(res_cost)), "result not registered")
  // The sequencer never takes a new weight while it still offers a result.
  `HFTC_ASSERT_NOW(a_no_accept_in_finish, res_valid, !in_ready, "weight accepted while result pending")
  // A total that could not be handed over stays offered and unchanged.
  `HFTC_ASSERT_NEXT(a_result_holds, res_valid && !res_take, res_valid && $stable(res_cost), "pending result lost")

endmodule

`default_nettype wire

// ===== dv/tb_huffman_total_code_cost.sv =====
// Self-checking testbench for huffman_total_code_cost: streams sets of weights through the
// valid/ready input channel and compares each total code cost with a built-in predictor.
// Depends on hftc_pkg and the huffman_total_code_cost RTL; reads no files.
module tb_huffman_total_code_cost;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [hftc_pkg::WEIGHT_W-1:0] in_weight      = '0;
  logic                          in_last        = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [hftc_pkg::COST_W-1:0]   out_total_cost;

  // Predictor state: the weights held for the set in progress and their running total.
  longint unsigned               held_weights[$];
  logic [hftc_pkg::COST_W-1:0]   running_total  = '0;
  // Costs of closed sets, oldest first, waiting for their out_ transaction.
  logic [hftc_pkg::COST_W-1:0]   expected_costs[$];

  int                  error_count    = 0;
  int                  items_sent     = 0;
  int                  cycle_count    = 0;
  int                  stall_left     = 0;
  bit                  idle_en        = 1'b1;

  huffman_total_code_cost #(
    .MAX_SYMBOLS(HEAP_DEPTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_weight     (in_weight),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_total_cost(out_total_cost)
  );

  always #5 clk = ~clk;

  // The watchdog bounds the whole run; a hang anywhere ends in the fail message.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d costs outstanding", cycle_count,
               expected_costs.size());
      $display("** huffman_total_code_cost: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Most gaps are zero or short; now and then a long one. With idling off the
  // channels run back to back.
  function automatic int pick_gap();
    int roll;
    if (!idle_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly full-range weights, with small values to force ties and the two extremes.
  function automatic logic [hftc_pkg::WEIGHT_W-1:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return hftc_pkg::WEIGHT_W'($urandom);
    if (roll < 90) return hftc_pkg::WEIGHT_W'($urandom_range(0, 15));
    return ($urandom_range(0, 1) != 0) ? {hftc_pkg::WEIGHT_W{1'b1}} : '0;
  endfunction

  function automatic logic [hftc_pkg::COST_W-1:0] add_saturating(
    input logic [hftc_pkg::COST_W-1:0] acc,
    input longint unsigned addend);
    longint unsigned sum;
    sum = longint'(acc) + addend;
    return (sum > longint'(hftc_pkg::COST_MAX)) ? hftc_pkg::COST_MAX :
                                                 hftc_pkg::COST_W'(sum);
  endfunction

  // Builds the Huffman tree for the held weights by merging the two smallest entries
  // until one is left. Every merge but the one that forms the root adds to the cost.
  // Which of two equal entries goes first does not matter for the sum.
  function automatic logic [hftc_pkg::COST_W-1:0] merge_cost(
    input logic [hftc_pkg::COST_W-1:0] leaf_total);
    longint unsigned             pool[$];
    longint unsigned             lo_a, lo_b, merged;
    logic [hftc_pkg::COST_W-1:0] cost;
    pool = held_weights;
    cost = leaf_total;
    while (pool.size() > 1) begin
      pool.sort();
      lo_a   = pool.pop_front();
      lo_b   = pool.pop_front();
      merged = lo_a + lo_b;
      if (pool.size() > 0) cost = add_saturating(cost, merged);
      pool.push_back(merged);
    end
    return cost;
  endfunction

  // Updates the predictor for one accepted input transaction. A weight that arrives
  // with the heap already full is dropped, but a marked one still closes the set.
  task automatic absorb_weight(input logic [hftc_pkg::WEIGHT_W-1:0] weight,
                               input logic set_end);
    if (held_weights.size() < HEAP_DEPTH) begin
      held_weights.push_back(64'(weight));
      running_total = add_saturating(running_total, 64'(weight));
    end
    if (set_end) begin
      expected_costs.push_back(merge_cost(running_total));
      held_weights.delete();
      running_total = '0;
    end
  endtask

  // Sends one weight. Valid is left high on return so that a back-to-back transaction
  // keeps it asserted; a gap lowers it first, in a later time step than the raise.
  task automatic send_weight(input logic [hftc_pkg::WEIGHT_W-1:0] weight,
                             input logic set_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_weight <= weight;
    in_last   <= set_end;
    do @(posedge clk); while (!in_ready);
    absorb_weight(weight, set_end);
    items_sent++;
  endtask

  task automatic send_set(input logic [hftc_pkg::WEIGHT_W-1:0] weights[$]);
    foreach (weights[i]) send_weight(weights[i], i == weights.size() - 1);
  endtask

  // Result side: random stalls of the same shape as the input gaps.
  always @(posedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every out_ transaction is matched against the oldest predicted cost.
  always @(posedge clk) begin : check_costs
    logic [hftc_pkg::COST_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_costs.size() == 0) begin
        report_mismatch($sformatf("result with none pending: total_cost=%0d",
                                  out_total_cost));
      end else begin
        want = expected_costs.pop_front();
        if (out_total_cost !== want)
          report_mismatch($sformatf("total_cost=%0d, predicted %0d", out_total_cost, want));
      end
    end
  end

  // A set of one weight must return that weight unchanged, at both ends of the range.
  task automatic test_single_weight_sets();
    idle_en = 1'b1;
    send_set('{16'h0000});
    send_set('{16'hFFFF});
    send_set('{16'h0001});
    send_set('{16'h8000});
  endtask

  // Zero weights are ordinary symbols; a zero next to a nonzero weight still costs a level.
  task automatic test_zero_weights();
    send_set('{16'h0000, 16'h0000, 16'h0000});
    send_set('{16'h0000, 16'h0005});
  endtask

  // Equal weights tie at every merge, then a mixed set spans both extremes; the cost must not depend on tie order.
  task automatic test_ties_and_extremes();
    send_set('{16'h0007, 16'h0007, 16'h0007, 16'h0007});
    send_set('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA});
  endtask

  // Fills the heap to its depth with large weights, then offers two more: both are
  // dropped, and the marked one still closes the set.
  task automatic test_heap_overflow();
    int total;
    total = HEAP_DEPTH + 2;
    idle_en = 1'b1;
    for (int i = 0; i < total; i++) begin
      send_weight(($urandom_range(0, 3) == 0) ? {hftc_pkg::WEIGHT_W{1'b1}} :
                  hftc_pkg::WEIGHT_W'($urandom_range(16'hF000, 16'hFFFF)), i == total - 1);
    end
  endtask

  // Random sets, mostly short so the merge phase stays quick, a few of a few dozen.
  // Idling is switched per set so that some stretches run without any gaps.
  task automatic test_random_sets();
    int start, set_len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) send_weight(pick_weight(), i == set_len - 1);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_weight_sets();
    test_zero_weights();
    test_ties_and_extremes();
    test_heap_overflow();
    test_random_sets();

    in_valid <= 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** huffman_total_code_cost: PASSED **");
    end else begin
      $display("** huffman_total_code_cost: FAILED **");
    end
    $finish;
  end

endmodule
